/* rtl/tlc_pkg.sv */
// shared types, constants and display helpers for the two-way traffic light controller
// used by tlc_step and two_way_traffic_light_controller_top; no dependencies
package tlc_pkg;

   localparam int CNT_W = 8;
   localparam int DUR_W = 7;
   localparam int SUM_W = 9;

   localparam logic [CNT_W-1:0] COUNT_MINUS_ONE = '1;
   localparam logic [DUR_W-1:0] DISPLAY_MAX     = 7'd99;

   typedef enum logic [2:0] {
      MODE_INIT       = 3'd0,
      MODE_NORMAL     = 3'd1,
      MODE_MOD_RED    = 3'd2,
      MODE_MOD_YELLOW = 3'd3,
      MODE_MOD_GREEN  = 3'd4,
      MODE_ERROR      = 3'd5
   } tlc_mode_type;

   typedef enum logic [1:0] {
      PHASE_RG = 2'd0,
      PHASE_RY = 2'd1,
      PHASE_GR = 2'd2,
      PHASE_YR = 2'd3
   } tlc_phase_type;

   typedef enum logic [1:0] {
      COLOR_RED    = 2'd0,
      COLOR_YELLOW = 2'd1,
      COLOR_GREEN  = 2'd2
   } tlc_color_type;

   typedef struct packed {
      logic             second_tick;
      logic             blink_tick;
      logic             mode_press;
      logic             set_press;
      logic [DUR_W-1:0] entry_value;
   } tlc_event_type;

   typedef struct packed {
      tlc_mode_type     mode;
      tlc_phase_type    phase;
      logic [CNT_W-1:0] way_one_count;
      logic [CNT_W-1:0] way_two_count;
      logic [DUR_W-1:0] red_duration;
      logic [DUR_W-1:0] yellow_duration;
      logic [DUR_W-1:0] green_duration;
      logic             blink_phase;
   } tlc_state_type;

   typedef struct packed {
      tlc_mode_type     mode;
      tlc_color_type    light_one;
      tlc_color_type    light_two;
      logic [DUR_W-1:0] display_left;
      logic [DUR_W-1:0] display_right;
      logic             blink_on;
      logic             error_flag;
   } tlc_result_type;

   // negative counts show as zero, large ones saturate
   function automatic logic [DUR_W-1:0] show_count(input logic [CNT_W-1:0] c);
      logic [DUR_W-1:0] r;
      if (c[CNT_W-1]) r = '0;
      else if (c[DUR_W-1:0] > DISPLAY_MAX) r = DISPLAY_MAX;
      else r = c[DUR_W-1:0];
      return r;
   endfunction

   function automatic logic [DUR_W-1:0] show_entry(input logic [DUR_W-1:0] e);
      return (e > DISPLAY_MAX) ? DISPLAY_MAX : e;
   endfunction

endpackage

/* rtl/tlc_step.sv */
// next-state and result logic for one request of the traffic light controller
// depends on tlc_pkg
module tlc_step #(
   parameter int DEFAULT_RED    = 5,
   parameter int DEFAULT_YELLOW = 1,
   parameter int DEFAULT_GREEN  = 3
) (
   input  tlc_pkg::tlc_event_type  evt,
   input  tlc_pkg::tlc_state_type  cur,
   output tlc_pkg::tlc_state_type  nxt,
   output tlc_pkg::tlc_result_type res
);

   localparam logic [tlc_pkg::DUR_W-1:0] DEF_RED    = DEFAULT_RED[tlc_pkg::DUR_W-1:0];
   localparam logic [tlc_pkg::DUR_W-1:0] DEF_YELLOW = DEFAULT_YELLOW[tlc_pkg::DUR_W-1:0];
   localparam logic [tlc_pkg::DUR_W-1:0] DEF_GREEN  = DEFAULT_GREEN[tlc_pkg::DUR_W-1:0];

   logic [tlc_pkg::SUM_W-1:0] red_side;
   logic [tlc_pkg::SUM_W-1:0] yg_side;

   always_comb begin
      nxt      = cur;
      red_side = '0;
      yg_side  = '0;
      case (cur.mode)
         tlc_pkg::MODE_NORMAL: begin
            if (evt.second_tick) begin
               nxt.way_one_count = cur.way_one_count - 8'd1;
               nxt.way_two_count = cur.way_two_count - 8'd1;
            end
            case (cur.phase)
               tlc_pkg::PHASE_RG: begin
                  if (nxt.way_two_count == tlc_pkg::COUNT_MINUS_ONE) begin
                     nxt.phase         = tlc_pkg::PHASE_RY;
                     nxt.way_two_count = {1'b0, cur.yellow_duration};
                  end
               end
               tlc_pkg::PHASE_RY: begin
                  if (nxt.way_two_count == tlc_pkg::COUNT_MINUS_ONE) begin
                     nxt.phase         = tlc_pkg::PHASE_GR;
                     nxt.way_one_count = {1'b0, cur.green_duration};
                     nxt.way_two_count = {1'b0, cur.red_duration};
                  end
               end
               tlc_pkg::PHASE_GR: begin
                  if (nxt.way_one_count == tlc_pkg::COUNT_MINUS_ONE) begin
                     nxt.phase         = tlc_pkg::PHASE_YR;
                     nxt.way_one_count = {1'b0, cur.yellow_duration};
                  end
               end
               default: begin
                  if (nxt.way_one_count == tlc_pkg::COUNT_MINUS_ONE) begin
                     nxt.phase         = tlc_pkg::PHASE_RG;
                     nxt.way_one_count = {1'b0, cur.red_duration};
                     nxt.way_two_count = {1'b0, cur.green_duration};
                  end
               end
            endcase
            if (evt.mode_press) begin
               nxt.mode          = tlc_pkg::MODE_MOD_RED;
               nxt.phase         = tlc_pkg::PHASE_RG;
               nxt.way_one_count = {1'b0, cur.red_duration};
               nxt.way_two_count = {1'b0, cur.green_duration};
               nxt.blink_phase   = 1'b0;
            end
         end
         tlc_pkg::MODE_MOD_RED, tlc_pkg::MODE_MOD_YELLOW, tlc_pkg::MODE_MOD_GREEN: begin
            if (evt.set_press) begin
               if (cur.mode == tlc_pkg::MODE_MOD_RED) nxt.red_duration = evt.entry_value;
               else if (cur.mode == tlc_pkg::MODE_MOD_YELLOW)
                  nxt.yellow_duration = evt.entry_value;
               else nxt.green_duration = evt.entry_value;
            end
            if (evt.blink_tick) nxt.blink_phase = ~cur.blink_phase;
            // durations must satisfy red + 1 == yellow + green + 2
            red_side = {2'b00, nxt.red_duration} + 9'd1;
            yg_side  = {2'b00, nxt.yellow_duration} + {2'b00, nxt.green_duration} + 9'd2;
            if (evt.mode_press) begin
               if (cur.mode == tlc_pkg::MODE_MOD_GREEN) begin
                  if (red_side == yg_side) begin
                     nxt.mode          = tlc_pkg::MODE_NORMAL;
                     nxt.phase         = tlc_pkg::PHASE_RG;
                     nxt.way_one_count = {1'b0, nxt.red_duration};
                     nxt.way_two_count = {1'b0, nxt.green_duration};
                  end else begin
                     nxt.mode = tlc_pkg::MODE_ERROR;
                  end
               end else begin
                  nxt.mode = (cur.mode == tlc_pkg::MODE_MOD_RED) ?
                             tlc_pkg::MODE_MOD_YELLOW : tlc_pkg::MODE_MOD_GREEN;
                  nxt.blink_phase = 1'b0;
               end
            end
         end
         tlc_pkg::MODE_ERROR: begin
            if (evt.mode_press) nxt.mode = tlc_pkg::MODE_INIT;
         end
         default: begin
            // init and unused codes reload defaults
            nxt.red_duration    = DEF_RED;
            nxt.yellow_duration = DEF_YELLOW;
            nxt.green_duration  = DEF_GREEN;
            nxt.phase           = tlc_pkg::PHASE_RG;
            nxt.way_one_count   = {1'b0, DEF_RED};
            nxt.way_two_count   = {1'b0, DEF_GREEN};
            nxt.mode            = tlc_pkg::MODE_NORMAL;
         end
      endcase
   end

   always_comb begin
      res = '0;
      res.mode      = nxt.mode;
      res.light_one = tlc_pkg::COLOR_RED;
      res.light_two = tlc_pkg::COLOR_RED;
      case (nxt.mode)
         tlc_pkg::MODE_MOD_RED, tlc_pkg::MODE_MOD_YELLOW, tlc_pkg::MODE_MOD_GREEN: begin
            if (nxt.mode == tlc_pkg::MODE_MOD_RED) begin
               res.light_one = tlc_pkg::COLOR_RED;
               res.light_two = tlc_pkg::COLOR_RED;
            end else if (nxt.mode == tlc_pkg::MODE_MOD_YELLOW) begin
               res.light_one = tlc_pkg::COLOR_YELLOW;
               res.light_two = tlc_pkg::COLOR_YELLOW;
            end else begin
               res.light_one = tlc_pkg::COLOR_GREEN;
               res.light_two = tlc_pkg::COLOR_GREEN;
            end
            res.display_left  = {4'b0000, nxt.mode};
            res.display_right = tlc_pkg::show_entry(evt.entry_value);
            res.blink_on      = nxt.blink_phase;
         end
         tlc_pkg::MODE_ERROR: begin
            res.error_flag = 1'b1;
         end
         default: begin
            case (nxt.phase)
               tlc_pkg::PHASE_RG: begin
                  res.light_one = tlc_pkg::COLOR_RED;
                  res.light_two = tlc_pkg::COLOR_GREEN;
               end
               tlc_pkg::PHASE_RY: begin
                  res.light_one = tlc_pkg::COLOR_RED;
                  res.light_two = tlc_pkg::COLOR_YELLOW;
               end
               tlc_pkg::PHASE_GR: begin
                  res.light_one = tlc_pkg::COLOR_GREEN;
                  res.light_two = tlc_pkg::COLOR_RED;
               end
               default: begin
                  res.light_one = tlc_pkg::COLOR_YELLOW;
                  res.light_two = tlc_pkg::COLOR_RED;
               end
            endcase
            res.display_left  = tlc_pkg::show_count(nxt.way_one_count);
            res.display_right = tlc_pkg::show_count(nxt.way_two_count);
         end
      endcase
   end

endmodule

/* rtl/two_way_traffic_light_controller_top.sv */
// two-way traffic light controller: request register, step logic, response register
// depends on tlc_pkg and tlc_step
//
// usage:
//   each request carries one set of events (second tick, blink tick,
//   mode press, set press, entered value). every request produces exactly one
//   response with the mode, both lamp colors, two display values, blink and error.
//   both channels use valid/stall; a transfer happens when valid is high and stall
//   is low. rsp_valid is driven from a register and never looks at rsp_stall.
//   a request moves from the request register into the response register;
//   throughput: one request per cycle while rsp_stall is low; the controller
//   state is updated in a single pass of the step logic as the request moves.
//   when the receiver stalls, the response register holds, the request register
//   fills, and req_stall rises only once both are occupied.
//   reset (synchronous, active high) empties both registers and puts the
//   controller in init mode with the default durations loaded; the first request
//   after reset reloads defaults and enters normal mode.
//
module two_way_traffic_light_controller_top #(
   parameter int DEFAULT_RED    = 5,
   parameter int DEFAULT_YELLOW = 1,
   parameter int DEFAULT_GREEN  = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_second_tick,
   input  logic       req_blink_tick,
   input  logic       req_mode_press,
   input  logic       req_set_press,
   input  logic [6:0] req_entry_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_mode,
   output logic [1:0] rsp_light_one,
   output logic [1:0] rsp_light_two,
   output logic [6:0] rsp_display_left,
   output logic [6:0] rsp_display_right,
   output logic       rsp_blink_on,
   output logic       rsp_error_flag
);

   localparam logic [tlc_pkg::DUR_W-1:0] RST_RED    = DEFAULT_RED[tlc_pkg::DUR_W-1:0];
   localparam logic [tlc_pkg::DUR_W-1:0] RST_YELLOW = DEFAULT_YELLOW[tlc_pkg::DUR_W-1:0];
   localparam logic [tlc_pkg::DUR_W-1:0] RST_GREEN  = DEFAULT_GREEN[tlc_pkg::DUR_W-1:0];

   logic                   req_valid_ff, req_valid_in;
   tlc_pkg::tlc_event_type req_evt_ff, req_evt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tlc_pkg::tlc_result_type rsp_res_ff, rsp_res_in;
   tlc_pkg::tlc_state_type state_ff, state_in;

   tlc_pkg::tlc_state_type  step_nxt;
   tlc_pkg::tlc_result_type step_res;
   logic                    rsp_free;
   logic                    advance;
   logic                    req_take;

   tlc_step #(
      .DEFAULT_RED   (DEFAULT_RED),
      .DEFAULT_YELLOW(DEFAULT_YELLOW),
      .DEFAULT_GREEN (DEFAULT_GREEN)
   ) u_step (
      .evt(req_evt_ff),
      .cur(state_ff),
      .nxt(step_nxt),
      .res(step_res)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !advance);
      req_evt_in   = req_evt_ff;
      if (req_take) begin
         req_evt_in.second_tick = req_second_tick;
         req_evt_in.blink_tick  = req_blink_tick;
         req_evt_in.mode_press  = req_mode_press;
         req_evt_in.set_press   = req_set_press;
         req_evt_in.entry_value = req_entry_value;
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_res_in   = advance ? step_res : rsp_res_ff;
      // controller state moves only when a request is consumed
      state_in     = advance ? step_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff             <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.mode            <= tlc_pkg::MODE_INIT;
         state_ff.phase           <= tlc_pkg::PHASE_RG;
         state_ff.way_one_count   <= {1'b0, RST_RED};
         state_ff.way_two_count   <= {1'b0, RST_GREEN};
         state_ff.red_duration    <= RST_RED;
         state_ff.yellow_duration <= RST_YELLOW;
         state_ff.green_duration  <= RST_GREEN;
         state_ff.blink_phase     <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_evt_ff <= req_evt_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_res_ff.mode;
   assign rsp_light_one     = rsp_res_ff.light_one;
   assign rsp_light_two     = rsp_res_ff.light_two;
   assign rsp_display_left  = rsp_res_ff.display_left;
   assign rsp_display_right = rsp_res_ff.display_right;
   assign rsp_blink_on      = rsp_res_ff.blink_on;
   assign rsp_error_flag    = rsp_res_ff.error_flag;

`ifndef SYNTHESIS
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("controller state changed without a consumed request");

   a_error_flag_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_mode == tlc_pkg::MODE_ERROR)
      else $error("error flag outside error mode");

   a_modify_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == tlc_pkg::MODE_MOD_RED || rsp_mode == tlc_pkg::MODE_MOD_YELLOW
                    || rsp_mode == tlc_pkg::MODE_MOD_GREEN)
      |-> rsp_light_one == rsp_light_two)
      else $error("lamps differ in modify mode");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_free |=> req_valid_ff)
      else $error("held request lost");
`endif

endmodule
